### sv/ghfs_pkg.sv
// ----------------------------------------------------------------------------
// ghfs_pkg: shared types and constants for the height/fog splat map
// Command codes, exp tables, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ghfs_pkg;

  localparam logic [1:0] CMD_SPLAT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_SPLAT_RADIUS   = 3'd2;
  localparam logic [2:0] REG_FOG_ENABLE     = 3'd3;
  localparam logic [2:0] REG_HEIGHT_ENABLE  = 3'd4;
  localparam logic [2:0] REG_FOG_FALLOFF    = 3'd5;
  localparam logic [2:0] REG_HEIGHT_FALLOFF = 3'd6;

  localparam logic [15:0] ALPHA_07 = 16'd45875;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_init;
    logic clr_we;
    logic sel_clr;
    logic sel_read;
    logic mem_re;
    logic mem_we;
    logic next_cell;
    logic e_en;
    logic w_en;
    logic m_en;
    logic out_load;
  } ghfs_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic on_grid;
    logic last_cell;
    logic clr_last;
    logic out_free;
  } ghfs_sts_t;

  // round(65536 * e^-k)
  function automatic logic [16:0] exp_whole(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536 * e^-(f/16))
  function automatic logic [16:0] exp_frac(input logic [3:0] f);
    logic [16:0] v;
    case (f)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/ghfs_ram.sv
// ----------------------------------------------------------------------------
// ghfs_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghfs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

`default_nettype wire

### sv/ghfs_dp.sv
// ----------------------------------------------------------------------------
// ghfs_dp: splat map datapath
// Item capture, offset counters, weight pipeline, map RAM, clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ghfs_dp #(
  parameter int MAX_GRID_WIDTH  = 64,
  parameter int MAX_GRID_HEIGHT = 64,
  parameter int MAX_RADIUS      = 31
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ghfs_pkg::ghfs_ctl_t ctl,
  output ghfs_pkg::ghfs_sts_t     sts,
  // config
  input  wire logic [6:0]         grid_width,
  input  wire logic [6:0]         grid_height,
  input  wire logic [4:0]         splat_radius,
  input  wire logic               fog_enable,
  input  wire logic               height_enable,
  input  wire logic [15:0]        fog_falloff,
  input  wire logic [15:0]        height_falloff,
  // item fields
  input  wire logic [15:0]        pos_x,
  input  wire logic [15:0]        pos_y,
  input  wire logic signed [23:0] target_height,
  input  wire logic [5:0]         read_row,
  input  wire logic [5:0]         read_col,
  // result
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [39:0]             out_tdata
);

  localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SWW   = $clog2(MAX_GRID_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_GRID_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = RW + 1;
  localparam int GW    = ((SWW > SHW) ? SWW : SHW) + RW + 2;
  localparam int DW    = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int EW    = DW + 16;

  // clamped config
  logic [SWW-1:0] gw_c;
  logic [SHW-1:0] gh_c;
  logic [RW-1:0]  r_c;

  always_comb begin
    if (grid_width == 7'd0) begin
      gw_c = SWW'(1);
    end else if (int'(grid_width) > MAX_GRID_WIDTH) begin
      gw_c = SWW'(MAX_GRID_WIDTH);
    end else begin
      gw_c = SWW'(grid_width);
    end
    if (grid_height == 7'd0) begin
      gh_c = SHW'(1);
    end else if (int'(grid_height) > MAX_GRID_HEIGHT) begin
      gh_c = SHW'(MAX_GRID_HEIGHT);
    end else begin
      gh_c = SHW'(grid_height);
    end
    if (int'(splat_radius) > MAX_RADIUS) begin
      r_c = RW'(MAX_RADIUS);
    end else begin
      r_c = RW'(splat_radius);
    end
  end

  logic signed [OW-1:0] r_pos;
  logic signed [OW-1:0] r_neg;
  assign r_pos = $signed({1'b0, r_c});
  assign r_neg = -r_pos;

  // captured item
  logic [SWW-1:0]        col_r;
  logic [SHW-1:0]        row_r;
  logic signed [23:0]    tgt_r;
  logic [5:0]            rrow_r;
  logic [5:0]            rcol_r;
  logic [16+SWW-1:0]     colp;
  logic [16+SHW-1:0]     rowp;

  assign colp = pos_x * gw_c;
  assign rowp = pos_y * gh_c;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      col_r  <= colp[16+SWW-1:16];
      row_r  <= rowp[16+SHW-1:16];
      tgt_r  <= target_height;
      rrow_r <= read_row;
      rcol_r <= read_col;
    end
  end

  // offset counters
  logic signed [OW-1:0] oi_r, oi_nxt;
  logic signed [OW-1:0] oj_r, oj_nxt;

  always_comb begin
    oi_nxt = oi_r;
    oj_nxt = oj_r;
    if (ctl.load) begin
      oi_nxt = r_neg;
      oj_nxt = r_neg;
    end else if (ctl.next_cell) begin
      if (oj_r == r_pos) begin
        oj_nxt = r_neg;
        oi_nxt = oi_r + OW'(1);
      end else begin
        oj_nxt = oj_r + OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
    oj_r <= oj_nxt;
  end

  logic signed [GW-1:0] ir_s;
  logic signed [GW-1:0] ic_s;
  logic [AW-1:0]        cell_addr;

  assign ir_s = $signed(GW'(row_r)) + GW'(oi_r);
  assign ic_s = $signed(GW'(col_r)) + GW'(oj_r);
  assign cell_addr = AW'(ir_s[GW-2:0]) * AW'(MAX_GRID_WIDTH) + AW'(ic_s[GW-2:0]);

  assign sts.on_grid = !ir_s[GW-1] && (ir_s[GW-2:0] < (GW-1)'(gh_c)) &&
                       !ic_s[GW-1] && (ic_s[GW-2:0] < (GW-1)'(gw_c));
  assign sts.last_cell = (oi_r == r_pos) && (oj_r == r_pos);

  // squared distance, registered every cycle
  logic [2*OW-1:0] sqi, sqj;
  logic [DW-1:0]   d2_r;
  assign sqi = (2*OW)'(oi_r) * (2*OW)'(oi_r);
  assign sqj = (2*OW)'(oj_r) * (2*OW)'(oj_r);
  always_ff @(posedge clk) begin
    d2_r <= DW'(sqi) + DW'(sqj);
  end

  // exponent stage
  logic [EW-1:0] ef_r, eh_r;
  always_ff @(posedge clk) begin
    if (ctl.e_en) begin
      ef_r <= d2_r * fog_falloff;
      eh_r <= d2_r * height_falloff;
    end
  end

  // weight stage
  logic [33:0] wfp, whp;
  logic [16:0] wf_r, wh_r;
  logic        ef_big, eh_big;
  assign ef_big = (ef_r[EW-1:16] >= (EW-16)'(12));
  assign eh_big = (eh_r[EW-1:16] >= (EW-16)'(12));
  assign wfp = 34'(ghfs_pkg::exp_whole(ef_r[19:16])) * 34'(ghfs_pkg::exp_frac(ef_r[15:12]))
               + 34'd32768;
  assign whp = 34'(ghfs_pkg::exp_whole(eh_r[19:16])) * 34'(ghfs_pkg::exp_frac(eh_r[15:12]))
               + 34'd32768;

  always_ff @(posedge clk) begin
    if (ctl.w_en) begin
      wf_r <= ef_big ? 17'd0 : wfp[32:16];
      wh_r <= eh_big ? 17'd0 : whp[32:16];
    end
  end

  // map RAM: {height, alpha}
  logic [39:0]        rdata;
  logic [15:0]        old_a;
  logic signed [23:0] old_h;
  assign old_a = rdata[15:0];
  assign old_h = $signed(rdata[39:16]);

  // multiply stage
  logic [32:0]        candp_r;
  logic signed [24:0] diff;
  logic signed [42:0] hp_r;
  assign diff = 25'(tgt_r) - 25'(old_h);
  always_ff @(posedge clk) begin
    if (ctl.m_en) begin
      candp_r <= 33'(ghfs_pkg::ALPHA_07) * 33'(wf_r);
      hp_r    <= 43'(diff) * $signed({26'd0, wh_r});
    end
  end

  // write-back
  logic [32:0]        cand_sum;
  logic [15:0]        cand;
  logic signed [42:0] hq_sum;
  logic [15:0]        new_a;
  logic signed [23:0] new_h;
  assign cand_sum = candp_r + 33'd32768;
  assign cand     = cand_sum[31:16];
  assign hq_sum   = hp_r + 43'sd32768;
  assign new_a    = (fog_enable && cand > old_a) ? cand : old_a;
  assign new_h    = height_enable ? (old_h + hq_sum[39:16]) : old_h;

  // clear sweep
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (ctl.clr_init) begin
      clr_addr_nxt = '0;
    end else if (ctl.clr_we) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end
  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));

  // read address
  logic          rd_in;
  logic [AW-1:0] rd_addr;
  assign rd_in   = (int'(rrow_r) < int'(gh_c)) && (int'(rcol_r) < int'(gw_c));
  assign rd_addr = AW'(rrow_r) * AW'(MAX_GRID_WIDTH) + AW'(rcol_r);

  logic [AW-1:0] ram_addr;
  logic [39:0]   ram_wdata;
  always_comb begin
    if (ctl.sel_clr) begin
      ram_addr  = clr_addr_r;
      ram_wdata = {24'd0, fog_enable ? 16'd0 : ghfs_pkg::ALPHA_07};
    end else if (ctl.sel_read) begin
      ram_addr  = rd_addr;
      ram_wdata = {new_h, new_a};
    end else begin
      ram_addr  = cell_addr;
      ram_wdata = {new_h, new_a};
    end
  end

  ghfs_ram #(
    .WIDTH (40),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ctl.clr_we | ctl.mem_we),
    .re    (ctl.mem_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  // result register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_tdata <= rd_in ? rdata : 40'd0;
    end
  end
  assign out_tvalid   = out_valid_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

### sv/ghfs_ctrl.sv
// ----------------------------------------------------------------------------
// ghfs_ctrl: splat map controller
// Sequences clear sweeps, per-cell read-modify-write, and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ghfs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic [1:0]          in_command,
  output logic                     in_tready,
  input  wire ghfs_pkg::ghfs_sts_t sts,
  output ghfs_pkg::ghfs_ctl_t      ctl
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_E     = 4'd3;
  localparam logic [3:0] S_W     = 4'd4;
  localparam logic [3:0] S_M     = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_RWAIT = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_CLR: begin
        ctl.sel_clr = 1'b1;
        ctl.clr_we  = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load = 1'b1;
          case (in_command)
            ghfs_pkg::CMD_SPLAT: state_nxt = S_RD;
            ghfs_pkg::CMD_READ:  state_nxt = S_RRD;
            ghfs_pkg::CMD_CLEAR: begin
              ctl.clr_init = 1'b1;
              state_nxt    = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (sts.on_grid) begin
          ctl.mem_re = 1'b1;
          state_nxt  = S_E;
        end else if (sts.last_cell) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.next_cell = 1'b1;
        end
      end
      S_E: begin
        ctl.e_en  = 1'b1;
        state_nxt = S_W;
      end
      S_W: begin
        ctl.w_en  = 1'b1;
        state_nxt = S_M;
      end
      S_M: begin
        ctl.m_en  = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        ctl.mem_we = 1'b1;
        if (sts.last_cell) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.next_cell = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RRD: begin
        ctl.sel_read = 1'b1;
        ctl.mem_re   = 1'b1;
        state_nxt    = S_RWAIT;
      end
      S_RWAIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/gaussian_height_fog_splat_top.sv
// ----------------------------------------------------------------------------
// gaussian_height_fog_splat_top: Gaussian height and fog splat map
// Grid of alpha/height cells updated by Gaussian splats, read one cell at a time.
// ----------------------------------------------------------------------------
// Splat: each on-grid cell of the (2r+1)^2 square passes the read, exponent,
//   weight, multiply and write states, an off-grid cell only the read state;
//   the single map RAM port does one read-modify-write per cell. Read: the
//   cell is read, then loaded into the result register once that is free;
//   clear: MAX_GRID_WIDTH*MAX_GRID_HEIGHT cells (4096), one cell a cycle.
// One item in flight at a time. Reset (rst_n low, synchronous) restores the
//   register defaults and clears the map, with in_tready low until done.
`default_nettype none

module gaussian_height_fog_splat_top #(
  parameter int MAX_GRID_WIDTH  = 64,
  parameter int MAX_GRID_HEIGHT = 64,
  parameter int MAX_RADIUS      = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pos_x[15:0], pos_y[31:16], target_height[55:32], read_row[61:56],
  // read_col[67:62], zero pad[71:68]
  input  wire logic [71:0] in_tdata,
  // command[1:0]
  input  wire logic [1:0]  in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_alpha[15:0], cell_height[39:16]
  output logic [39:0]      out_tdata,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Register i sits at byte address 4*i; the low
  // address bits are not decoded. Index 7 is unmapped and ignored.
  // --------------------------------------------------------------------------
  logic [6:0]  grid_width_r;
  logic [6:0]  grid_height_r;
  logic [4:0]  splat_radius_r;
  logic        fog_enable_r;
  logic        height_enable_r;
  logic [15:0] fog_falloff_r;
  logic [15:0] height_falloff_r;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= 7'd64;
      grid_height_r    <= 7'd64;
      splat_radius_r   <= 5'd15;
      fog_enable_r     <= 1'b0;
      height_enable_r  <= 1'b0;
      fog_falloff_r    <= 16'd146;
      height_falloff_r <= 16'd328;
    end else if (wr_en) begin
      case (reg_idx)
        ghfs_pkg::REG_GRID_WIDTH:     grid_width_r     <= cfg_pwdata[6:0];
        ghfs_pkg::REG_GRID_HEIGHT:    grid_height_r    <= cfg_pwdata[6:0];
        ghfs_pkg::REG_SPLAT_RADIUS:   splat_radius_r   <= cfg_pwdata[4:0];
        ghfs_pkg::REG_FOG_ENABLE:     fog_enable_r     <= cfg_pwdata[0];
        ghfs_pkg::REG_HEIGHT_ENABLE:  height_enable_r  <= cfg_pwdata[0];
        ghfs_pkg::REG_FOG_FALLOFF:    fog_falloff_r    <= cfg_pwdata[15:0];
        ghfs_pkg::REG_HEIGHT_FALLOFF: height_falloff_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ghfs_pkg::REG_GRID_WIDTH:     cfg_prdata = {25'd0, grid_width_r};
      ghfs_pkg::REG_GRID_HEIGHT:    cfg_prdata = {25'd0, grid_height_r};
      ghfs_pkg::REG_SPLAT_RADIUS:   cfg_prdata = {27'd0, splat_radius_r};
      ghfs_pkg::REG_FOG_ENABLE:     cfg_prdata = {31'd0, fog_enable_r};
      ghfs_pkg::REG_HEIGHT_ENABLE:  cfg_prdata = {31'd0, height_enable_r};
      ghfs_pkg::REG_FOG_FALLOFF:    cfg_prdata = {16'd0, fog_falloff_r};
      ghfs_pkg::REG_HEIGHT_FALLOFF: cfg_prdata = {16'd0, height_falloff_r};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller and datapath. The controller only accepts a transaction in
  // its idle state; the datapath owns the map RAM and the result register,
  // so a finished read waits there without blocking the next transaction.
  // --------------------------------------------------------------------------
  ghfs_pkg::ghfs_ctl_t ctl;
  ghfs_pkg::ghfs_sts_t sts;

  ghfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  ghfs_dp #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
    .MAX_RADIUS      (MAX_RADIUS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .grid_width     (grid_width_r),
    .grid_height    (grid_height_r),
    .splat_radius   (splat_radius_r),
    .fog_enable     (fog_enable_r),
    .height_enable  (height_enable_r),
    .fog_falloff    (fog_falloff_r),
    .height_falloff (height_falloff_r),
    .pos_x          (in_tdata[15:0]),
    .pos_y          (in_tdata[31:16]),
    .target_height  ($signed(in_tdata[55:32])),
    .read_row       (in_tdata[61:56]),
    .read_col       (in_tdata[67:62]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_tdata      (out_tdata)
  );

endmodule

`default_nettype wire
